/* rtl/core/mbls_pkg.sv */
// Package for the multi-bearer link selector: metric record, event and class
// codes, state encoding, per-bearer reset values, score tables, divide-by-ten.
// No dependencies.
package mbls_pkg;

    localparam int NB      = 5;
    localparam int SCORE_W = 21;

    localparam logic signed [SCORE_W-1:0] REJECT_SCORE = -21'sd1000000;

    // event codes
    localparam logic [2:0] REQ_SET_AVAIL = 3'd0;
    localparam logic [2:0] REQ_SET_REACH = 3'd1;
    localparam logic [2:0] REQ_SET_CLASS = 3'd2;
    localparam logic [2:0] REQ_SUCCESS   = 3'd3;
    localparam logic [2:0] REQ_FAILURE   = 3'd4;
    localparam logic [2:0] REQ_RETRY     = 3'd5;
    localparam logic [2:0] REQ_DECIDE    = 3'd6;

    // link classes
    localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
    localparam logic [2:0] CLS_POOR     = 3'd1;
    localparam logic [2:0] CLS_MARGINAL = 3'd2;
    localparam logic [2:0] CLS_GOOD     = 3'd3;
    localparam logic [2:0] CLS_STRONG   = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_STALE  = 2'd0;
    localparam logic [1:0] CFG_HOLD   = 2'd1;
    localparam logic [1:0] CFG_MARGIN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_D,
        ST_DIV_L,
        ST_DIV_R,
        ST_WB,
        ST_SCAN,
        ST_HOLD,
        ST_ALT,
        ST_FIN,
        ST_OUT
    } mbls_state_t;

    typedef struct packed {
        logic        avail;
        logic        reach;
        logic [9:0]  deliv;
        logic [15:0] lat;
        logic [9:0]  retry;
        logic [2:0]  cls;
        logic [7:0]  fail;
        logic [31:0] last_ms;
    } mbls_rec_t;

    function automatic mbls_rec_t init_rec(input logic [2:0] b);
        mbls_rec_t r;
        r = '0;
        case (b)
            3'd0: begin r.deliv = 10'd780; r.lat = 16'd950; r.cls = CLS_GOOD;     end
            3'd1: begin r.deliv = 10'd600; r.lat = 16'd300; r.cls = CLS_UNKNOWN;  end
            3'd2: begin r.deliv = 10'd820; r.lat = 16'd180; r.cls = CLS_GOOD;     end
            3'd3: begin r.deliv = 10'd700; r.lat = 16'd260; r.cls = CLS_MARGINAL; end
            default: begin r.deliv = 10'd650; r.lat = 16'd450; r.cls = CLS_UNKNOWN; end
        endcase
        return r;
    endfunction

    function automatic logic signed [SCORE_W-1:0] class_points(input logic [2:0] c);
        case (c)
            CLS_STRONG:   return 21'sd700;
            CLS_GOOD:     return 21'sd450;
            CLS_MARGINAL: return 21'sd150;
            CLS_POOR:     return 21'sd0;
            default:      return 21'sd30;
        endcase
    endfunction

    // kind bonus - min(2*transition, 1600) - min(energy, 1000), folded per bearer
    function automatic logic signed [SCORE_W-1:0] fixed_points(input logic [2:0] b);
        case (b)
            3'd0:    return -21'sd340;
            3'd1:    return -21'sd2020;
            3'd2:    return -21'sd300;
            3'd3:    return -21'sd740;
            default: return -21'sd1260;
        endcase
    endfunction

    // sub-GHz radio for bearers 0 and 1, 2.4 GHz for the rest
    function automatic logic radio_of(input logic [2:0] b);
        return (b > 3'd1);
    endfunction

    // exact floor(x/10) for x < 2^22 by reciprocal multiply
    function automatic logic [19:0] div10(input logic [19:0] x);
        logic [42:0] p;
        p = 43'(x) * 43'd838861;
        return p[42:23];
    endfunction

endpackage

/* rtl/core/mbls_score.sv */
// Score of one bearer from its metric record.
// Depends on mbls_pkg.
module mbls_score
    import mbls_pkg::*;
#(
    parameter int NUM_BEARERS = NB
) (
    input  mbls_rec_t                         rec,
    input  logic [$clog2(NUM_BEARERS)-1:0]    idx,
    input  logic [31:0]                       now_ms,
    input  logic [31:0]                       stale_limit_ms,
    output logic signed [SCORE_W-1:0]         score
);

    logic [31:0] age;
    logic        stale;
    logic [11:0] lat_c;
    logic [10:0] r2;
    logic [10:0] r_c;
    logic [16:0] f400;
    logic signed [SCORE_W-1:0] raw;

    always_comb begin
        age   = now_ms - rec.last_ms;
        stale = (rec.last_ms != 32'd0) && (age > stale_limit_ms) && (idx != '0);
        lat_c = (rec.lat > 16'd3000) ? 12'd3000 : rec.lat[11:0];
        r2    = {rec.retry, 1'b0};
        r_c   = (r2 > 11'd1600) ? 11'd1600 : r2;
        f400  = 17'(rec.fail) * 17'd400;
        raw   = $signed({8'b0, rec.deliv, 3'b0})
              + class_points(rec.cls)
              - $signed({9'b0, lat_c})
              - $signed({10'b0, r_c})
              - $signed({4'b0, f400})
              + fixed_points(3'(idx));
        if (!rec.avail || !rec.reach || stale) begin
            score = REJECT_SCORE;
        end else begin
            score = raw;
        end
    end

endmodule

/* rtl/core/multi_bearer_link_selector.sv */
// Multi-bearer link selector top level: metric memory, event sequencer, decision.
// Depends on mbls_pkg and mbls_score.
//
// Usage:
//  - s_* channel carries event beats (valid/ready). Events 0..5 update the
//    metric record of one bearer; a decide event (6) yields one m_* beat with
//    primary/backup bearers, their scores and the advised retry rounds, FEC
//    and fragment size. Other events give no result; update events on bearers
//    5..7 and request code 7 are dropped at acceptance.
//  - cfg_we/cfg_index/cfg_data write the stale limit, hold window and switch
//    margin; write only while idle.
//  - One event at a time. A metric update runs from acceptance to the next
//    accept through read, three divide-by-ten steps on a shared reciprocal
//    multiplier and write-back. A decide runs through a pipelined read/score
//    pass over the five memory entries, hold check, optional backup pass
//    (when the backup must be searched on the other radio) and result load.
//  - The result sits in an output register; s_ready returns while it waits,
//    so update events proceed under a stalled receiver. A following decide
//    waits in its last step until the output register frees.
//  - Reset: all metrics read as their per-bearer defaults (valid bit per
//    entry), no previous decision, config registers at defaults. No clearing
//    pass is needed.
module multi_bearer_link_selector
    import mbls_pkg::*;
#(
    parameter int NUM_BEARERS = NB
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_req_type,
    input  logic [2:0]                s_bearer,
    input  logic                      s_flag,
    input  logic [2:0]                s_link_class,
    input  logic [15:0]               s_latency_ms,
    input  logic [31:0]               s_now_ms,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_has_primary,
    output logic [2:0]                m_primary_bearer,
    output logic signed [SCORE_W-1:0] m_primary_score,
    output logic                      m_has_backup,
    output logic [2:0]                m_backup_bearer,
    output logic signed [SCORE_W-1:0] m_backup_score,
    output logic [2:0]                m_retry_rounds,
    output logic                      m_use_fec,
    output logic [7:0]                m_fragment_bytes
);

    localparam int BW    = $clog2(NUM_BEARERS);
    localparam int CNT_W = $clog2(NUM_BEARERS + 2);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_BEARERS + 1);
    localparam logic [CNT_W-1:0] ALT_LAST  = CNT_W'(NUM_BEARERS - 1);

    // config
    logic [31:0] stale_reg, hold_reg;
    logic [16:0] margin_reg;

    // sequencer
    mbls_state_t state_reg, state_next;
    logic [2:0]  req_reg, cls_in_reg;
    logic [BW-1:0] bidx_reg;
    logic        flag_reg;
    logic [15:0] lat_in_reg;
    logic [31:0] now_reg;
    logic [CNT_W-1:0] cnt_reg;

    // metric memory
    mbls_rec_t   mem [NUM_BEARERS];
    logic [NUM_BEARERS-1:0] valid_reg;
    logic        rd_en, wr_en;
    logic [BW-1:0] rd_addr;
    mbls_rec_t   rd_rec_reg, eff, wr_rec;
    logic        rd_vld_reg;
    logic [BW-1:0] rd_idx_reg;

    // update datapath
    mbls_rec_t   wrk_reg;
    logic [19:0] num_d_reg, num_l_reg, num_r_reg;
    logic [9:0]  q_d_reg, q_r_reg;
    logic [15:0] q_l_reg;
    logic [19:0] div_in, div_out;

    // decide datapath
    logic signed [SCORE_W-1:0] score, sc_reg, best_reg, second_reg, ps_reg, bs_reg, ds_reg;
    logic [BW-1:0] sc_idx_reg, best_b_reg, second_b_reg, pb_reg, bb_reg, db_reg;
    logic signed [SCORE_W-1:0] scores_reg [NUM_BEARERS];
    logic [2:0]  clsa_reg [NUM_BEARERS];
    logic        hp_reg, hb_reg, alt_reg;
    logic        have_prev_reg;
    logic [BW-1:0] prev_pb_reg;
    logic [31:0] prev_ms_reg;

    // output register
    logic        m_valid_reg;
    logic        out_load;

    // hold-window evaluation
    logic signed [SCORE_W-1:0] old_s;
    logic signed [SCORE_W:0]   old_plus;
    logic        hold_hit, hp_n, hb_n, alt_n;
    logic [BW-1:0] pb_n, bb_n;
    logic signed [SCORE_W-1:0] ps_n, bs_n;
    logic [31:0] since_dec;
    logic signed [SCORE_W:0]   ds_plus;

    logic in_acc, upd_ok;
    logic [2:0]  pcls;
    logic [7:0]  fail_n;

    assign in_acc  = s_valid && s_ready;
    assign upd_ok  = (s_req_type != REQ_DECIDE) && (s_req_type != 3'd7) &&
                     (32'(s_bearer) < 32'(NUM_BEARERS));
    assign s_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg  <= 32'd30000;
            hold_reg   <= 32'd5000;
            margin_reg <= 17'd150;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STALE:  stale_reg  <= cfg_data;
                CFG_HOLD:   hold_reg   <= cfg_data;
                CFG_MARGIN: margin_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_req_type == REQ_DECIDE) state_next = ST_SCAN;
                    else if (upd_ok)              state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_DIV_D;
            ST_DIV_D: state_next = ST_DIV_L;
            ST_DIV_L: state_next = ST_DIV_R;
            ST_DIV_R: state_next = ST_WB;
            ST_WB:    state_next = ST_IDLE;
            ST_SCAN:  if (cnt_reg == SCAN_LAST) state_next = ST_HOLD;
            ST_HOLD:  state_next = alt_n ? ST_ALT : ST_FIN;
            ST_ALT:   if (cnt_reg == ALT_LAST) state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // memory read control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == ST_IDLE && in_acc) begin
            if (s_req_type == REQ_DECIDE) begin
                rd_en = 1'b1;
            end else if (upd_ok) begin
                rd_en   = 1'b1;
                rd_addr = s_bearer[BW-1:0];
            end
        end else if (state_reg == ST_SCAN && cnt_reg < CNT_W'(NUM_BEARERS)) begin
            rd_en   = 1'b1;
            rd_addr = cnt_reg[BW-1:0];
        end
    end

    // unwritten entries read as their reset record
    assign eff = rd_vld_reg ? rd_rec_reg : init_rec(3'(rd_idx_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) mem[bidx_reg] <= wr_rec;
        if (rd_en) rd_rec_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            if (wr_en) valid_reg[bidx_reg] <= 1'b1;
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
                rd_idx_reg <= rd_addr;
            end
        end
    end

    // shared divide-by-ten
    always_comb begin
        case (state_reg)
            ST_DIV_L: div_in = num_l_reg;
            ST_DIV_R: div_in = num_r_reg;
            default:  div_in = num_d_reg;
        endcase
        div_out = div10(div_in);
    end

    // write-back record
    always_comb begin
        wr_en  = (state_reg == ST_WB);
        wr_rec = wrk_reg;
        fail_n = (wrk_reg.fail < 8'd255) ? wrk_reg.fail + 8'd1 : wrk_reg.fail;
        case (req_reg)
            REQ_SET_AVAIL: begin
                wr_rec.avail = flag_reg;
                if (!flag_reg) begin
                    wr_rec.reach = 1'b0;
                    wr_rec.fail  = 8'd0;
                end
            end
            REQ_SET_REACH: wr_rec.reach = flag_reg;
            REQ_SET_CLASS: wr_rec.cls = cls_in_reg;
            REQ_SUCCESS: begin
                wr_rec.avail = 1'b1;
                wr_rec.reach = 1'b1;
                wr_rec.deliv = q_d_reg;
                wr_rec.lat   = q_l_reg;
                wr_rec.retry = q_r_reg;
                wr_rec.fail  = 8'd0;
                if (q_d_reg >= 10'd900)      wr_rec.cls = CLS_STRONG;
                else if (q_d_reg >= 10'd760) wr_rec.cls = CLS_GOOD;
                else                         wr_rec.cls = CLS_MARGINAL;
            end
            REQ_FAILURE: begin
                wr_rec.deliv = q_d_reg;
                wr_rec.fail  = fail_n;
                if (fail_n >= 8'd2) wr_rec.cls = CLS_POOR;
                if (fail_n >= 8'd3 && bidx_reg != '0) wr_rec.reach = 1'b0;
            end
            default: wr_rec.retry = (q_r_reg > 10'd1000) ? 10'd1000 : q_r_reg;
        endcase
        wr_rec.last_ms = now_reg;
    end

    mbls_score #(
        .NUM_BEARERS(NUM_BEARERS)
    ) u_score (
        .rec            (eff),
        .idx            (rd_idx_reg),
        .now_ms         (now_reg),
        .stale_limit_ms (stale_reg),
        .score          (score)
    );

    // hold window and backup radio check
    always_comb begin
        old_s     = scores_reg[prev_pb_reg];
        old_plus  = {old_s[SCORE_W-1], old_s} + $signed({5'b0, margin_reg});
        since_dec = now_reg - prev_ms_reg;
        hp_n      = (best_reg != REJECT_SCORE);
        hold_hit  = have_prev_reg && hp_n && (best_b_reg != prev_pb_reg) &&
                    (since_dec < hold_reg) && (old_s != REJECT_SCORE) &&
                    ($signed({best_reg[SCORE_W-1], best_reg}) < old_plus);
        if (hold_hit) begin
            pb_n = prev_pb_reg;  ps_n = old_s;
            bb_n = best_b_reg;   bs_n = best_reg;  hb_n = 1'b1;
        end else begin
            pb_n = best_b_reg;   ps_n = best_reg;
            bb_n = second_b_reg; bs_n = second_reg;
            hb_n = (second_reg != REJECT_SCORE);
        end
        alt_n   = hp_n && hb_n && (radio_of(3'(pb_n)) == radio_of(3'(bb_n)));
        ds_plus = {ds_reg[SCORE_W-1], ds_reg} + (SCORE_W+1)'(250);
        pcls    = clsa_reg[pb_reg];
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    req_reg    <= s_req_type;
                    bidx_reg   <= s_bearer[BW-1:0];
                    flag_reg   <= s_flag;
                    cls_in_reg <= s_link_class;
                    lat_in_reg <= s_latency_ms;
                    now_reg    <= s_now_ms;
                    cnt_reg    <= CNT_W'(1);
                    best_reg   <= REJECT_SCORE;
                    second_reg <= REJECT_SCORE;
                    best_b_reg   <= '0;
                    second_b_reg <= '0;
                end
            end
            ST_PREP: begin
                wrk_reg   <= eff;
                num_d_reg <= 20'(eff.deliv) * 20'd7 +
                             ((req_reg == REQ_SUCCESS) ? 20'd3000 : 20'd0);
                num_l_reg <= 20'(eff.lat) * 20'd7 + 20'(lat_in_reg) * 20'd3;
                num_r_reg <= {7'b0, eff.retry, 3'b0} +
                             ((req_reg == REQ_RETRY) ? 20'd2000 : 20'd0);
            end
            ST_DIV_D: q_d_reg <= div_out[9:0];
            ST_DIV_L: q_l_reg <= div_out[15:0];
            ST_DIV_R: q_r_reg <= div_out[9:0];
            ST_SCAN: begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg <= CNT_W'(NUM_BEARERS)) begin
                    sc_reg     <= score;
                    sc_idx_reg <= rd_idx_reg;
                    scores_reg[rd_idx_reg] <= score;
                    clsa_reg[rd_idx_reg]   <= eff.cls;
                end
                if (cnt_reg >= CNT_W'(2)) begin
                    if (sc_reg > best_reg) begin
                        second_reg   <= best_reg;
                        second_b_reg <= best_b_reg;
                        best_reg     <= sc_reg;
                        best_b_reg   <= sc_idx_reg;
                    end else if (sc_reg > second_reg) begin
                        second_reg   <= sc_reg;
                        second_b_reg <= sc_idx_reg;
                    end
                end
            end
            ST_HOLD: begin
                hp_reg  <= hp_n;
                hb_reg  <= hb_n;
                pb_reg  <= pb_n;
                ps_reg  <= ps_n;
                bb_reg  <= bb_n;
                bs_reg  <= bs_n;
                alt_reg <= alt_n;
                ds_reg  <= REJECT_SCORE;
                db_reg  <= bb_n;
                cnt_reg <= '0;
            end
            ST_ALT: begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (radio_of(3'(cnt_reg)) != radio_of(3'(pb_reg)) &&
                    scores_reg[cnt_reg[BW-1:0]] > ds_reg) begin
                    ds_reg <= scores_reg[cnt_reg[BW-1:0]];
                    db_reg <= cnt_reg[BW-1:0];
                end
            end
            ST_FIN: begin
                if (alt_reg && ds_reg != REJECT_SCORE &&
                    ds_plus >= $signed({bs_reg[SCORE_W-1], bs_reg})) begin
                    bb_reg <= db_reg;
                    bs_reg <= ds_reg;
                end
            end
            default: ;
        endcase
    end

    // previous decision and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_pb_reg   <= '0;
            prev_ms_reg   <= 32'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (hp_reg) begin
                    have_prev_reg <= 1'b1;
                    prev_pb_reg   <= pb_reg;
                    prev_ms_reg   <= now_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_has_primary    <= hp_reg;
            m_primary_bearer <= 3'(pb_reg);
            m_primary_score  <= ps_reg;
            m_has_backup     <= hb_reg;
            m_backup_bearer  <= 3'(bb_reg);
            m_backup_score   <= bs_reg;
            if (!hp_reg) begin
                m_retry_rounds <= 3'd2; m_use_fec <= 1'b0; m_fragment_bytes <= 8'd96;
            end else begin
                case (pcls)
                    CLS_STRONG: begin
                        m_retry_rounds <= 3'd1; m_use_fec <= 1'b0; m_fragment_bytes <= 8'd160;
                    end
                    CLS_GOOD: begin
                        m_retry_rounds <= 3'd2; m_use_fec <= 1'b0; m_fragment_bytes <= 8'd128;
                    end
                    CLS_MARGINAL: begin
                        m_retry_rounds <= 3'd3; m_use_fec <= 1'b1; m_fragment_bytes <= 8'd80;
                    end
                    default: begin
                        m_retry_rounds <= 3'd4; m_use_fec <= 1'b1; m_fragment_bytes <= 8'd56;
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    a_no_primary_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_primary) |-> (m_primary_score == REJECT_SCORE))
        else $error("primary score set without primary");

    a_no_backup_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_backup) |-> (m_backup_score == REJECT_SCORE))
        else $error("backup score set without backup");

    a_prev_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        have_prev_reg |-> (32'(prev_pb_reg) < 32'(NUM_BEARERS)))
        else $error("previous primary out of range");

    a_wb_only_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> $past(state_reg == ST_DIV_R))
        else $error("write-back without divide sequence");

endmodule
